// ----- rtl/core/cdg_pkg.sv -----
// shared types and constants for the coordinate deque with occupancy grid
// no dependencies; imported by cdg_grid and coordinate_deque_with_grid
package cdg_pkg;

	localparam int COORD_W   = 5;
	localparam int GRID_MAX  = 1 << COORD_W;
	localparam int CNT_OUT_W = 11;
	localparam int IN_W      = 16;
	localparam int OUT_W     = 48;
	localparam int OUT_PAD   = 4;

	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_QUERY      = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} cell_t;

	// one read and one write of the occupancy bitmap per cycle
	typedef struct packed {
		logic  rd_en;
		cell_t rd_cell;
		logic  wr_en;
		cell_t wr_cell;
		logic  wr_mark;
	} grid_req_t;

endpackage

// ----- rtl/core/cdg_grid.sv -----
// occupancy bitmap of the grid: synchronous memory, clearing pass after reset,
// forwarding of a same-cycle write to the registered read; uses cdg_pkg
module cdg_grid #(
	parameter int GRID_SIZE = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cdg_pkg::grid_req_t req,
	output logic              busy,
	output logic              mark
);
	import cdg_pkg::*;

	localparam int GEFF   = (GRID_SIZE < GRID_MAX) ? GRID_SIZE : GRID_MAX;
	localparam int GCELLS = GEFF * GEFF;
	localparam int GA_W   = $clog2(GCELLS);

	function automatic logic [GA_W-1:0] cell_addr(input cell_t c);
		return GA_W'(int'(c.x) * GEFF + int'(c.y));
	endfunction

	logic            mark_mem [GCELLS];
	logic            busy_q;
	logic [GA_W-1:0] clr_idx_q;
	logic            rd_q;
	logic            fwd_s1;
	logic            fwd_val_s1;
	logic [GA_W-1:0] rd_addr;
	logic [GA_W-1:0] wr_addr;

	assign rd_addr = cell_addr(req.rd_cell);
	assign wr_addr = cell_addr(req.wr_cell);

	// clearing pass, one cell a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + GA_W'(1);
			if (clr_idx_q == GA_W'(GCELLS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mark_mem[clr_idx_q] <= 1'b0;
		end else if (req.wr_en) begin
			mark_mem[wr_addr] <= req.wr_mark;
		end
		if (req.rd_en) begin
			rd_q       <= mark_mem[rd_addr];
			fwd_s1     <= req.wr_en && (wr_addr == rd_addr);
			fwd_val_s1 <= req.wr_mark;
		end
	end

	assign busy = busy_q;
	assign mark = fwd_s1 ? fwd_val_s1 : rd_q;

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (!req.rd_en && !req.wr_en))
		else $error("grid request during clearing pass");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> !busy_q)
		else $error("clearing pass restarted");

	a_clear_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> ($past(clr_idx_q) == GA_W'(GCELLS - 1)))
		else $error("clearing pass ended early");

endmodule

// ----- rtl/core/coordinate_deque_with_grid.sv -----
// deque of grid cells in a ring buffer memory plus a grid occupancy bitmap
// result word registered in S_FINISH once the output is free; no new operation is
// accepted before then; S_FINISH waits on the registered entry memory read after a pop
// reset: head, count and handshakes clear; the bitmap is swept clear, one cell
// a cycle, over all grid cells (1024 by default) before the first accept
// depends on cdg_pkg and cdg_grid
module coordinate_deque_with_grid #(
	parameter int GRID_SIZE = 32,
	parameter int CAPACITY  = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// opcode[2:0], cell_x[7:3], cell_y[12:8], zero pad
	input  logic [cdg_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// status[1:0], front_x[6:2], front_y[11:7], rear_x[16:12], rear_y[21:17],
	// entry_count[32:22], popped_x[37:33], popped_y[42:38], cell_occupied[43],
	// zero pad
	output logic [cdg_pkg::OUT_W-1:0] m_tdata
);
	import cdg_pkg::*;

	localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int SUM_W = CNT_W + 1;

	typedef enum logic {S_IDLE, S_FINISH} state_t;

	function automatic logic in_grid(input cell_t c);
		return (int'(c.x) < GRID_SIZE) && (int'(c.y) < GRID_SIZE);
	endfunction

	// ring buffer storage, entries are read only after they were written
	cell_t      entry_mem [CAPACITY];
	cell_t      entry_rd_q;

	state_t     state_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	cell_t      front_q;
	cell_t      rear_q;

	// decode stage results, held until the result word is formed
	status_t    status_s1;
	cell_t      popped_s1;
	logic       load_front_s1;
	logic       load_rear_s1;
	logic       occ_ok_s1;

	logic       accept;
	opcode_t    op;
	cell_t      in_cell;
	logic       is_full;
	logic       is_empty;
	logic       push_ok;
	logic       pop_ok;
	logic       at_front;
	status_t    status_d;
	cell_t      popped_d;
	logic [PTR_W-1:0] head_dec;
	logic [PTR_W-1:0] head_inc;
	logic [PTR_W-1:0] ins_pos;
	logic [PTR_W-1:0] rear_prev;
	logic [SUM_W-1:0] sum_ins;
	logic [SUM_W-1:0] sum_rp;
	logic       mem_we;
	logic [PTR_W-1:0] mem_wa;
	logic       mem_re;
	logic [PTR_W-1:0] mem_ra;
	grid_req_t  grid_req;
	logic       grid_busy;
	logic       grid_mark;
	logic       out_free;
	cell_t      front_o;
	cell_t      rear_o;
	logic [OUT_W-1:0] result_d;

	assign op        = opcode_t'(s_tdata[2:0]);
	assign in_cell.x = s_tdata[7:3];
	assign in_cell.y = s_tdata[12:8];

	assign s_tready = (state_q == S_IDLE) && !grid_busy;
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	// ring pointer arithmetic, sums stay below twice the capacity
	assign head_dec = (head_q == '0) ? PTR_W'(CAPACITY - 1) : head_q - PTR_W'(1);
	assign head_inc = (head_q == PTR_W'(CAPACITY - 1)) ? '0 : head_q + PTR_W'(1);
	assign sum_ins  = SUM_W'(head_q) + SUM_W'(count_q);
	assign sum_rp   = sum_ins - SUM_W'(2);
	assign ins_pos  = (sum_ins >= SUM_W'(CAPACITY)) ? PTR_W'(sum_ins - SUM_W'(CAPACITY))
	                                                : PTR_W'(sum_ins);
	// next rear after a pop from the rear, used only when entries remain
	assign rear_prev = (sum_rp >= SUM_W'(CAPACITY)) ? PTR_W'(sum_rp - SUM_W'(CAPACITY))
	                                                : PTR_W'(sum_rp);

	// operation decode; unused opcodes behave as a query
	always_comb begin
		push_ok  = 1'b0;
		pop_ok   = 1'b0;
		at_front = 1'b0;
		status_d = ST_OK;
		unique case (op)
			OP_PUSH_FRONT: begin
				at_front = 1'b1;
				if (is_full) status_d = ST_OVERFLOW;
				else push_ok = 1'b1;
			end
			OP_PUSH_REAR: begin
				if (is_full) status_d = ST_OVERFLOW;
				else push_ok = 1'b1;
			end
			OP_POP_FRONT: begin
				at_front = 1'b1;
				if (is_empty) status_d = ST_UNDERFLOW;
				else pop_ok = 1'b1;
			end
			OP_POP_REAR: begin
				if (is_empty) status_d = ST_UNDERFLOW;
				else pop_ok = 1'b1;
			end
			OP_QUERY: ;
			default: ;
		endcase
	end

	assign popped_d = at_front ? front_q : rear_q;

	// entry memory ports: a push writes, a pop that leaves entries reads the new end
	assign mem_we = accept && push_ok;
	assign mem_wa = at_front ? head_dec : ins_pos;
	assign mem_re = accept && pop_ok && (count_q > CNT_W'(1));
	assign mem_ra = at_front ? head_inc : rear_prev;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[mem_wa] <= in_cell;
		end
		if (mem_re) begin
			entry_rd_q <= entry_mem[mem_ra];
		end
	end

	// bitmap: read the input cell, set on push, clear the popped cell on pop
	always_comb begin
		grid_req.rd_en   = accept && in_grid(in_cell);
		grid_req.rd_cell = in_cell;
		grid_req.wr_en   = accept && ((push_ok && in_grid(in_cell)) ||
		                              (pop_ok && in_grid(popped_d)));
		grid_req.wr_cell = push_ok ? in_cell : popped_d;
		grid_req.wr_mark = push_ok;
	end

	cdg_grid #(
		.GRID_SIZE(GRID_SIZE)
	) u_grid (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (grid_req),
		.busy  (grid_busy),
		.mark  (grid_mark)
	);

	// result word, front and rear refreshed from the memory read after a pop, zero when empty
	always_comb begin
		front_o = load_front_s1 ? entry_rd_q : front_q;
		rear_o  = load_rear_s1 ? entry_rd_q : rear_q;
		if (count_q == '0) begin
			front_o = '0;
			rear_o  = '0;
		end
		result_d = {{OUT_PAD{1'b0}}, occ_ok_s1 && grid_mark, popped_s1.y, popped_s1.x,
		            CNT_OUT_W'(count_q), rear_o.y, rear_o.x, front_o.y, front_o.x,
		            status_s1};
	end

	// control: handshake state, head, count and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			head_q   <= '0;
			count_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (m_tvalid && m_tready) begin
						m_tvalid <= 1'b0;
					end
					if (accept) begin
						state_q <= S_FINISH;
						if (push_ok) begin
							count_q <= count_q + CNT_W'(1);
							if (at_front) head_q <= head_dec;
						end else if (pop_ok) begin
							count_q <= count_q - CNT_W'(1);
							if (at_front) head_q <= head_inc;
						end
					end
				end
				S_FINISH: begin
					// hold here while the previous word is still waiting
					if (out_free) begin
						state_q  <= S_IDLE;
						m_tvalid <= 1'b1;
						m_tdata  <= result_d;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload: end caches and decode stage
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1     <= status_d;
			popped_s1     <= pop_ok ? popped_d : '0;
			load_front_s1 <= mem_re && at_front;
			load_rear_s1  <= mem_re && !at_front;
			occ_ok_s1     <= in_grid(in_cell);
			if (push_ok) begin
				if (at_front || is_empty) front_q <= in_cell;
				if (!at_front || is_empty) rear_q <= in_cell;
			end
		end
		if ((state_q == S_FINISH) && out_free) begin
			if (load_front_s1) front_q <= entry_rd_q;
			if (load_rear_s1) rear_q <= entry_rd_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_head_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(PTR_W + 1)'(head_q) < (PTR_W + 1)'(CAPACITY))
		else $error("head pointer outside ring");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
			((count_q == $past(count_q) + CNT_W'(1)) ||
			 (count_q == $past(count_q) - CNT_W'(1))))
		else $error("entry count moved by more than one");

	a_word_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == S_FINISH))
		else $error("result word without a finished operation");

endmodule
